// ----- hw/rtl/fmmc_pkg.sv -----
// Shared types, codes and defaults for the fuzzy max-min composition block.
`timescale 1ns / 1ps

package fmmc_pkg;

    localparam int DEFAULT_MATRIX_DIM = 8;
    localparam int DEFAULT_GRADE_BITS = 8;

    localparam int OP_W          = 2;
    localparam int IDX_FIELD_W   = 3;
    localparam int GRADE_FIELD_W = 8;
    localparam int SIZE_W        = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // One queued command from the front end to the back end
    typedef struct packed {
        logic                     compute;
        logic                     right;
        logic [IDX_FIELD_W-1:0]   row;
        logic [IDX_FIELD_W-1:0]   col;
        logic [GRADE_FIELD_W-1:0] grade;
    } cmd_t;

endpackage

// ----- hw/rtl/fmmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fmmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fmmc_front.sv -----
// Front end: accepts input transactions, drops no-ops, queues commands.
`timescale 1ns / 1ps

module fmmc_front #(
    parameter int MATRIX_DIM = fmmc_pkg::DEFAULT_MATRIX_DIM
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fmmc_pkg::OP_W-1:0]            operation,
    input  logic [fmmc_pkg::IDX_FIELD_W-1:0]     row,
    input  logic [fmmc_pkg::IDX_FIELD_W-1:0]     col,
    input  logic [fmmc_pkg::GRADE_FIELD_W-1:0]   grade,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output fmmc_pkg::cmd_t                       cmd
);

    import fmmc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic keep;
    logic in_range;
    logic push;
    logic pop;
    cmd_t new_cmd;

    assign in_range = (32'(row) < MATRIX_DIM) && (32'(col) < MATRIX_DIM);

    // out-of-range loads and the unused code are accepted and dropped here
    always_comb
    begin
        new_cmd.row   = row;
        new_cmd.col   = col;
        new_cmd.grade = grade;
        unique case (operation)
            OP_LOAD_LEFT:
            begin
                keep            = in_range;
                new_cmd.compute = 1'b0;
                new_cmd.right   = 1'b0;
            end
            OP_LOAD_RIGHT:
            begin
                keep            = in_range;
                new_cmd.compute = 1'b0;
                new_cmd.right   = 1'b1;
            end
            OP_COMPUTE:
            begin
                keep            = 1'b1;
                new_cmd.compute = 1'b1;
                new_cmd.right   = 1'b0;
            end
            default:
            begin
                keep            = 1'b0;
                new_cmd.compute = 1'b0;
                new_cmd.right   = 1'b0;
            end
        endcase
    end

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];

    assign push = in_valid && in_ready && keep;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- hw/rtl/fmmc_back.sv -----
// Back end: matrix stores, max-min sequencer and result register.
`timescale 1ns / 1ps

module fmmc_back #(
    parameter int MATRIX_DIM = fmmc_pkg::DEFAULT_MATRIX_DIM,
    parameter int GRADE_BITS = fmmc_pkg::DEFAULT_GRADE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  fmmc_pkg::cmd_t                       cmd,
    input  logic [fmmc_pkg::SIZE_W-1:0]          size_in_use,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fmmc_pkg::IDX_FIELD_W-1:0]     out_row,
    output logic [fmmc_pkg::IDX_FIELD_W-1:0]     out_col,
    output logic [fmmc_pkg::GRADE_FIELD_W-1:0]   out_grade,
    output logic                                 last
);

    import fmmc_pkg::*;

    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int IDX_W  = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] m_reg, m_next;
    logic [IDX_W-1:0] dlast_reg, dlast_next;

    logic             rd_valid_reg, rd_valid_next;
    logic             rd_first_reg, rd_first_next;
    logic             rd_last_reg, rd_last_next;
    logic             rd_end_reg, rd_end_next;
    logic [IDX_W-1:0] rd_i_reg, rd_i_next;
    logic [IDX_W-1:0] rd_k_reg, rd_k_next;

    logic [GRADE_BITS-1:0] acc_reg, acc_next;

    logic                     out_valid_reg, out_valid_next;
    logic [IDX_FIELD_W-1:0]   out_row_reg, out_row_next;
    logic [IDX_FIELD_W-1:0]   out_col_reg, out_col_next;
    logic [GRADE_FIELD_W-1:0] out_grade_reg, out_grade_next;
    logic                     out_last_reg, out_last_next;

    logic                  take;
    logic                  stall;
    logic                  issue;
    logic                  m_last, k_last, i_last;
    logic [IDX_W-1:0]      dlast_start;
    logic [ADDR_W-1:0]     waddr;
    logic [GRADE_BITS-1:0] wdata;
    logic                  we_left, we_right;
    logic [ADDR_W-1:0]     raddr_left, raddr_right;
    logic [GRADE_BITS-1:0] rdata_left, rdata_right;
    logic [GRADE_BITS-1:0] pair_min;
    logic [GRADE_BITS-1:0] running;

    // loads and computes never overlap, so the stores see no read-write clash
    assign cmd_ready = !busy_reg;
    assign take      = cmd_valid && cmd_ready;

    assign waddr    = ADDR_W'(IDX_W'(cmd.row)) * ADDR_W'(MATRIX_DIM) + ADDR_W'(IDX_W'(cmd.col));
    assign wdata    = GRADE_BITS'(cmd.grade);
    assign we_left  = take && !cmd.compute && !cmd.right;
    assign we_right = take && !cmd.compute && cmd.right;

    // clamp the size register to one..MATRIX_DIM, kept as the last index
    always_comb
    begin
        priority if (size_in_use == '0)
        begin
            dlast_start = '0;
        end
        else if (32'(size_in_use) > MATRIX_DIM)
        begin
            dlast_start = IDX_W'(MATRIX_DIM - 1);
        end
        else
        begin
            dlast_start = IDX_W'(size_in_use - 1'b1);
        end
    end

    // the final pair of a result must wait while the result register is held
    assign stall = rd_valid_reg && rd_last_reg && out_valid_reg && !out_ready;
    assign issue = busy_reg && !stall;

    assign m_last = (m_reg == dlast_reg);
    assign k_last = (k_reg == dlast_reg);
    assign i_last = (i_reg == dlast_reg);

    assign raddr_left  = ADDR_W'(i_reg) * ADDR_W'(MATRIX_DIM) + ADDR_W'(m_reg);
    assign raddr_right = ADDR_W'(m_reg) * ADDR_W'(MATRIX_DIM) + ADDR_W'(k_reg);

    fmmc_ram #(
        .WIDTH (GRADE_BITS),
        .DEPTH (CELLS)
    ) u_left_ram (
        .clk   (clk),
        .we    (we_left),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (raddr_left),
        .rdata (rdata_left)
    );

    fmmc_ram #(
        .WIDTH (GRADE_BITS),
        .DEPTH (CELLS)
    ) u_right_ram (
        .clk   (clk),
        .we    (we_right),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (raddr_right),
        .rdata (rdata_right)
    );

    assign pair_min = (rdata_left < rdata_right) ? rdata_left : rdata_right;
    assign running  = (rd_first_reg || pair_min > acc_reg) ? pair_min : acc_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        m_next        = m_reg;
        dlast_next    = dlast_reg;
        rd_valid_next = rd_valid_reg;
        rd_first_next = rd_first_reg;
        rd_last_next  = rd_last_reg;
        rd_end_next   = rd_end_reg;
        rd_i_next     = rd_i_reg;
        rd_k_next     = rd_k_reg;
        acc_next      = acc_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_grade_next = out_grade_reg;
        out_last_next  = out_last_reg;

        if (take && cmd.compute)
        begin
            busy_next  = 1'b1;
            i_next     = '0;
            k_next     = '0;
            m_next     = '0;
            dlast_next = dlast_start;
        end

        // fold the pair held in the read stage into the running maximum
        if (rd_valid_reg && !stall)
        begin
            if (rd_last_reg)
            begin
                out_valid_next = 1'b1;
                out_row_next   = IDX_FIELD_W'(rd_i_reg);
                out_col_next   = IDX_FIELD_W'(rd_k_reg);
                out_grade_next = GRADE_FIELD_W'(running);
                out_last_next  = rd_end_reg;
            end
            else
            begin
                acc_next = running;
            end
        end

        if (!stall)
        begin
            rd_valid_next = issue;
        end

        if (issue)
        begin
            rd_first_next = (m_reg == '0);
            rd_last_next  = m_last;
            rd_end_next   = m_last && k_last && i_last;
            rd_i_next     = i_reg;
            rd_k_next     = k_reg;
            if (m_last)
            begin
                m_next = '0;
                if (k_last)
                begin
                    k_next = '0;
                    if (i_last)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            else
            begin
                m_next = m_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        k_reg         <= k_next;
        m_reg         <= m_next;
        dlast_reg     <= dlast_next;
        rd_first_reg  <= rd_first_next;
        rd_last_reg   <= rd_last_next;
        rd_end_reg    <= rd_end_next;
        rd_i_reg      <= rd_i_next;
        rd_k_reg      <= rd_k_next;
        acc_reg       <= acc_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_grade_reg <= out_grade_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_grade = out_grade_reg;
    assign last      = out_last_reg;

endmodule

// ----- hw/rtl/fuzzy_max_min_composition.sv -----
// Top level of the fuzzy max-min composition block: size register and the two halves.
`timescale 1ns / 1ps

// Load transactions write one grade into the left or right matrix and pass
// through a four-entry command queue, one per cycle while the queue has room;
// loads with row or col at or beyond MATRIX_DIM and the unused operation code
// are taken and dropped. A compute emits d*d results in row-major order, d
// being size_in_use clamped to 1..MATRIX_DIM, and flags the final one with
// last. Each result is built by stepping m from 0 to d-1, reading one left
// and one right grade per cycle from the two matrix RAMs except while a low
// out_ready holds the result register, so a compute occupies the back end
// until it has issued every read. Commands queued behind a compute wait for
// it to finish. The matrices are not cleared by reset; compute only over
// entries already loaded. Write the size register only while the block is idle.
module fuzzy_max_min_composition #(
    parameter int MATRIX_DIM = fmmc_pkg::DEFAULT_MATRIX_DIM,
    parameter int GRADE_BITS = fmmc_pkg::DEFAULT_GRADE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fmmc_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fmmc_pkg::OP_W-1:0]            operation,
    input  logic [fmmc_pkg::IDX_FIELD_W-1:0]     row,
    input  logic [fmmc_pkg::IDX_FIELD_W-1:0]     col,
    input  logic [fmmc_pkg::GRADE_FIELD_W-1:0]   grade,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fmmc_pkg::IDX_FIELD_W-1:0]     out_row,
    output logic [fmmc_pkg::IDX_FIELD_W-1:0]     out_col,
    output logic [fmmc_pkg::GRADE_FIELD_W-1:0]   out_grade,
    output logic                                 last
);

    import fmmc_pkg::*;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_valid && cfg_ready)
        begin
            size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    fmmc_front #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .row       (row),
        .col       (col),
        .grade     (grade),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fmmc_back #(
        .MATRIX_DIM (MATRIX_DIM),
        .GRADE_BITS (GRADE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .size_in_use (size_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_grade   (out_grade),
        .last        (last)
    );

endmodule

// ----- hw/rtl/fmmc_checker.sv -----
// Port-level assertions for the fuzzy max-min composition block, bound to the top level.
`timescale 1ns / 1ps

module fmmc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic [fmmc_pkg::OP_W-1:0]            operation,
    input logic [fmmc_pkg::IDX_FIELD_W-1:0]     row,
    input logic [fmmc_pkg::IDX_FIELD_W-1:0]     col,
    input logic [fmmc_pkg::GRADE_FIELD_W-1:0]   grade,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [fmmc_pkg::IDX_FIELD_W-1:0]     out_row,
    input logic [fmmc_pkg::IDX_FIELD_W-1:0]     out_col,
    input logic [fmmc_pkg::GRADE_FIELD_W-1:0]   out_grade,
    input logic                                 last
);

    // an offered transaction holds its payload until taken
    a_in_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(row)
            && $stable(col) && $stable(grade)
    ) else $error("input changed while waiting");

    // a held result keeps its payload until taken
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(out_grade) && $stable(last)
    ) else $error("result changed while stalled");

    // the final result of a compute sits on the diagonal
    a_last_diag: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_row == out_col
    ) else $error("last result is off the diagonal");

    // reset leaves no result pending
    a_reset_idle: assert property (
        @(posedge clk)
        !rst_n |=> !out_valid
    ) else $error("result pending after reset");

endmodule

bind fuzzy_max_min_composition fmmc_checker u_fmmc_checker (.*);

// ----- tb/tb_fuzzy_max_min_composition.sv -----
// Self-checking testbench for the fuzzy max-min composition block.
`timescale 1ns / 1ps

module tb_fuzzy_max_min_composition;

    import fmmc_pkg::*;

    localparam int                DIM          = DEFAULT_MATRIX_DIM;
    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
    localparam int                PHASES       = 10;
    localparam int                PHASE_ITEMS  = 28;
    localparam int                DRAIN_CYCLES = 16;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]   row;
        logic [IDX_FIELD_W-1:0]   col;
        logic [GRADE_FIELD_W-1:0] grade;
        logic                     last;
    } entry_t;

    typedef struct packed {
        logic                     is_cfg;
        logic [SIZE_W-1:0]        size;
        logic [OP_W-1:0]          op;
        logic [IDX_FIELD_W-1:0]   r;
        logic [IDX_FIELD_W-1:0]   c;
        logic [GRADE_FIELD_W-1:0] g;
        logic                     typed;
        logic [GRADE_FIELD_W-1:0] exp_grade;
    } step_t;

    // Typed expectations are size-one computes, so the single entry is (0,0) with last set
    localparam step_t DIRECTED_STEPS [24] = '{
        '{1'b1, 4'd0, OP_LOAD_LEFT,  3'd0, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd0, 3'd0, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd0, 3'd0, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_COMPUTE,    3'd0, 3'd0, 8'd0,   1'b1, 8'd255},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd0, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_COMPUTE,    3'd5, 3'd2, 8'd77,  1'b1, 8'd0},
        '{1'b0, 4'd0, OP_UNUSED,     3'd7, 3'd7, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd0, 3'd0, 8'd200, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd0, 3'd0, 8'd100, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_COMPUTE,    3'd7, 3'd7, 8'd255, 1'b1, 8'd100},
        '{1'b1, 4'd1, OP_LOAD_LEFT,  3'd0, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd0, 3'd0, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_COMPUTE,    3'd0, 3'd0, 8'd0,   1'b1, 8'd200},
        '{1'b1, 4'd2, OP_LOAD_LEFT,  3'd0, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd0, 3'd1, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd1, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd1, 3'd1, 8'd128, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd0, 3'd1, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd1, 3'd0, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd1, 3'd1, 8'd7,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_COMPUTE,    3'd0, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_UNUSED,     3'd0, 3'd0, 8'd0,   1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_LEFT,  3'd7, 3'd7, 8'd255, 1'b0, 8'd0},
        '{1'b0, 4'd0, OP_LOAD_RIGHT, 3'd7, 3'd7, 8'd0,   1'b0, 8'd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [SIZE_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          operation;
    logic [IDX_FIELD_W-1:0]   row;
    logic [IDX_FIELD_W-1:0]   col;
    logic [GRADE_FIELD_W-1:0] grade;
    logic                     out_valid;
    logic                     out_ready;
    logic [IDX_FIELD_W-1:0]   out_row;
    logic [IDX_FIELD_W-1:0]   out_col;
    logic [GRADE_FIELD_W-1:0] out_grade;
    logic                     last;

    logic [GRADE_FIELD_W-1:0] left_grades [DIM*DIM];
    logic [GRADE_FIELD_W-1:0] right_grades [DIM*DIM];
    logic [SIZE_W-1:0]        size_setting;
    entry_t                   pending_entries [$];

    int mismatch_count;
    int burst_left;
    int idle_cycles;
    bit hold_request;

    fuzzy_max_min_composition dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .row       (row),
        .col       (col),
        .grade     (grade),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_grade (out_grade),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Append one expected entry behind the others
    task automatic queue_entry(input entry_t e);
        pending_entries = {pending_entries, e};
    endtask

    // Queue every composed entry of the current size, row-major
    task automatic predict_composition();
        int     d;
        entry_t e;
        logic [GRADE_FIELD_W-1:0] best;
        logic [GRADE_FIELD_W-1:0] lo;
        d = int'(size_setting);
        if (d == 0)
            d = 1;
        if (d > DIM)
            d = DIM;
        for (int i = 0; i < d; i++)
        begin
            for (int k = 0; k < d; k++)
            begin
                best = '0;
                for (int m = 0; m < d; m++)
                begin
                    lo = (left_grades[i*DIM+m] < right_grades[m*DIM+k]) ?
                         left_grades[i*DIM+m] : right_grades[m*DIM+k];
                    if (lo > best)
                        best = lo;
                end
                e.row   = IDX_FIELD_W'(i);
                e.col   = IDX_FIELD_W'(k);
                e.grade = best;
                e.last  = (i == d - 1) && (k == d - 1);
                queue_entry(e);
            end
        end
    endtask

    task automatic apply_item(input logic [OP_W-1:0] op, input logic [IDX_FIELD_W-1:0] r,
                              input logic [IDX_FIELD_W-1:0] c,
                              input logic [GRADE_FIELD_W-1:0] g);
        if (op == OP_LOAD_LEFT)
            left_grades[int'(r)*DIM + int'(c)] = g;
        else if (op == OP_LOAD_RIGHT)
            right_grades[int'(r)*DIM + int'(c)] = g;
        else if (op == OP_COMPUTE)
            predict_composition();
    endtask

    // Offer one transaction in bursts with random gaps; return once accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_FIELD_W-1:0] r,
                             input logic [IDX_FIELD_W-1:0] c,
                             input logic [GRADE_FIELD_W-1:0] g);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        row       <= r;
        col       <= c;
        grade     <= g;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drain every outstanding entry, let queued loads settle, then write the size
    task automatic write_size(input logic [SIZE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        size_setting = value;
    endtask

    function automatic logic [GRADE_FIELD_W-1:0] pick_grade();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return GRADE_FIELD_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'($urandom_range(9, 15));
            1, 2:    return SIZE_W'($urandom_range(5, 8));
            default: return SIZE_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Main sequence: directed table, full load of both matrices, random phases
    initial
    begin
        step_t                    s;
        int                       pick;
        int                       counted;
        logic [OP_W-1:0]          op;
        logic [SIZE_W-1:0]        sz;
        logic [GRADE_FIELD_W-1:0] g;
        entry_t                   e;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        operation      <= OP_LOAD_LEFT;
        row            <= '0;
        col            <= '0;
        grade          <= '0;
        mismatch_count = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        size_setting   = SIZE_RESET;
        for (int i = 0; i < DIM*DIM; i++)
        begin
            left_grades[i]  = '0;
            right_grades[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_STEPS[n])
        begin
            s = DIRECTED_STEPS[n];
            if (s.is_cfg)
                write_size(s.size);
            else
            begin
                send_item(s.op, s.r, s.c, s.g);
                if (s.typed)
                begin
                    e.row   = '0;
                    e.col   = '0;
                    e.grade = s.exp_grade;
                    e.last  = 1'b1;
                    queue_entry(e);
                end
                else
                    apply_item(s.op, s.r, s.c, s.g);
            end
        end

        // Write every cell so later computes never read an unloaded entry
        for (int i = 0; i < DIM*DIM; i++)
        begin
            g = pick_grade();
            send_item(OP_LOAD_LEFT, IDX_FIELD_W'(i / DIM), IDX_FIELD_W'(i % DIM), g);
            apply_item(OP_LOAD_LEFT, IDX_FIELD_W'(i / DIM), IDX_FIELD_W'(i % DIM), g);
            g = pick_grade();
            send_item(OP_LOAD_RIGHT, IDX_FIELD_W'(i % DIM), IDX_FIELD_W'(i / DIM), g);
            apply_item(OP_LOAD_RIGHT, IDX_FIELD_W'(i % DIM), IDX_FIELD_W'(i / DIM), g);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       sz = '1;
                1:       sz = SIZE_W'(DIM);
                2:       sz = '0;
                default: sz = pick_size();
            endcase
            write_size(sz);
            counted = 0;
            // Stall the output while a full-size compute and its followers pile up
            if (p == 1)
            begin
                hold_request = 1'b1;
                send_item(OP_COMPUTE, '0, '0, '0);
                apply_item(OP_COMPUTE, '0, '0, '0);
                counted++;
            end
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    op = OP_COMPUTE;
                else if (pick < 11)
                    op = OP_UNUSED;
                else
                    op = ($urandom_range(0, 1) == 0) ? OP_LOAD_LEFT : OP_LOAD_RIGHT;
                g = pick_grade();
                s.r = IDX_FIELD_W'($urandom_range(0, 7));
                s.c = IDX_FIELD_W'($urandom_range(0, 7));
                send_item(op, s.r, s.c, g);
                apply_item(op, s.r, s.c, g);
                if (op != OP_UNUSED)
                    counted++;
            end
        end

        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[fuzzy_max_min_composition] OK");
        else
            $display("[fuzzy_max_min_composition] ERROR");
        $finish;
    end

    // Output side: stall patterns of its own, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        out_ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= (tick % 4 != 3);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_entries.size() == 0)
                report_mismatch("result with nothing pending, grade", out_grade, 0);
            else
            begin
                want = pending_entries.pop_front();
                if (out_row !== want.row)
                    report_mismatch("out_row", out_row, want.row);
                if (out_col !== want.col)
                    report_mismatch("out_col", out_col, want.col);
                if (out_grade !== want.grade)
                    report_mismatch("out_grade", out_grade, want.grade);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // Abort if no transaction moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[fuzzy_max_min_composition] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
